// ===== rtl/ssnf_pkg.sv =====
// ssnf_pkg: shared types, format codes and the seven-segment font
`default_nettype none

package ssnf_pkg;

    // number of display positions
    localparam int DIGIT_COUNT = 4;

    // format selector codes
    localparam logic [2:0] FUNC_BLANK    = 3'd0;
    localparam logic [2:0] FUNC_HEX      = 3'd1;
    localparam logic [2:0] FUNC_UNSIGNED = 3'd2;
    localparam logic [2:0] FUNC_SIGNED   = 3'd3;
    localparam logic [2:0] FUNC_ASCII    = 3'd4;

    // fixed patterns for sign and error text
    localparam logic [7:0] SEG_PLUS  = 8'h70;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_E     = 8'h79;
    localparam logic [7:0] SEG_R     = 8'h33;

    // character codes used to reach digits and letters in the font
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // decimal range limits
    localparam logic [31:0] UNSIGNED_MAX = 32'd9999;
    localparam logic [31:0] NEG_MAG_MAX  = 32'd999;

    // font for codes space through DEL, bits 0..6 segments a..g, bit 7 point
    localparam logic [7:0] FONT [96] = '{
        8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20, 8'h29, 8'h0B,
        8'h21, 8'h70, 8'h10, 8'h40, 8'h80, 8'h52, 8'h3F, 8'h06, 8'h5B, 8'h4F,
        8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h61, 8'h48,
        8'h43, 8'hD3, 8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71,
        8'h3D, 8'h76, 8'h30, 8'h1E, 8'h75, 8'h38, 8'h15, 8'h37, 8'h3F, 8'h73,
        8'h6B, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
        8'h39, 8'h64, 8'h0F, 8'h23, 8'h08, 8'h02,
        8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F, 8'h74, 8'h10, 8'h0C,
        8'h75, 8'h30, 8'h14, 8'h54, 8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
        8'h1C, 8'h1C, 8'h14, 8'h76, 8'h6E, 8'h5B,
        8'h46, 8'h30, 8'h70, 8'h01, 8'h00
    };

    // decimal digits, index 0 is the leftmost
    typedef logic [DIGIT_COUNT-1:0][3:0] t_bcd;

    // input beat
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [7:0] digit_zero;
        logic [7:0] digit_one;
        logic [7:0] digit_two;
        logic [7:0] digit_three;
    } t_out_beat;

    // pattern for one character code, codes outside space..DEL show a space, DEL shows the tilde
    function automatic logic [7:0] glyph(input logic [7:0] code);
        logic [7:0] c;
        logic [6:0] idx;
        c   = (code == CHAR_DEL) ? CHAR_TILDE : code;
        idx = 7'(c - CHAR_SPACE);
        if (code < CHAR_SPACE || code > CHAR_DEL) begin
            return FONT[0];
        end
        return FONT[idx];
    endfunction

    // pattern for one nibble shown as 0-9, A-F
    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        if (nib > 4'd9) begin
            return glyph(CHAR_A + wide - 8'd10);
        end
        return glyph(CHAR_ZERO + wide);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssnf_decimal.sv =====
// ssnf_decimal: splits a binary value below 10000 into four decimal digits
`default_nettype none

module ssnf_decimal
    import ssnf_pkg::*;
(
    input  wire logic [13:0] i_bin,
    output t_bcd             o_dec
);

    // reciprocals exact for every 14-bit input
    localparam logic [14:0] RECIP_10   = 15'd13108;  // 2^17 / 10, rounded up
    localparam logic [13:0] RECIP_100  = 14'd10486;  // 2^20 / 100, rounded up
    localparam logic [14:0] RECIP_1000 = 15'd16778;  // 2^24 / 1000, rounded up

    logic [28:0] prod10;
    logic [27:0] prod100;
    logic [28:0] prod1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [13:0] q10_x10;
    logic [9:0]  q100_x10;
    logic [6:0]  q1000_x10;

    // independent quotients by 10, 100 and 1000
    always_comb begin
        prod10   = 29'(i_bin) * 29'(RECIP_10);
        prod100  = 28'(i_bin) * 28'(RECIP_100);
        prod1000 = 29'(i_bin) * 29'(RECIP_1000);
        q10      = prod10[26:17];
        q100     = prod100[26:20];
        q1000    = prod1000[27:24];
    end

    // digits from the difference of neighboring quotients
    always_comb begin
        q10_x10   = 14'({q10, 3'b000}) + 14'({q10, 1'b0});
        q100_x10  = 10'({q100, 3'b000}) + 10'({q100, 1'b0});
        q1000_x10 = 7'({q1000, 3'b000}) + 7'({q1000, 1'b0});
        o_dec[0]  = q1000;
        o_dec[1]  = 4'(q100 - q1000_x10);
        o_dec[2]  = 4'(q10 - q100_x10);
        o_dec[3]  = 4'(i_bin - q10_x10);
    end

endmodule

`default_nettype wire

// ===== rtl/seven_segment_number_formatter.sv =====
// seven_segment_number_formatter: value and format in, four segment patterns out
`default_nettype none

// Formats a 32-bit word for a four-digit seven-segment display: blank, hex of
// the low 16 bits, unsigned decimal 0..9999 with leading zeros, signed decimal
// -999..9999 with leading zeros blanked and a floating minus, or four ASCII
// characters (byte 0 leftmost). Out-of-range decimal values show +ERR or -ERR.
// One beat is taken every clock cycle unless the output side stalls; a beat's
// result passes through the input register and then the result register that
// bracket the decimal split and font lookup. Stall on the output side reaches
// the input side in the same cycle only when both registers hold a beat.

module seven_segment_number_formatter
    import ssnf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_beat  i_data,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_beat      o_data
);

    logic        r_in_valid;
    logic [2:0]  r_func;
    logic [31:0] r_value;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic        in_load;
    logic        out_load;

    logic [31:0] mag;
    logic        neg;
    logic [31:0] dec_src;
    logic        over_pos;
    logic        over_neg;
    t_bcd        dec;
    logic [1:0]  first;
    logic [7:0]  n_digits [DIGIT_COUNT];
    t_out_beat   n_out;

    // pipeline flow control
    assign out_load = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && !out_load;
    assign in_load  = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
        if (in_load) begin
            r_func  <= i_data.func;
            r_value <= i_data.value;
        end
    end

    // sign handling and range checks
    always_comb begin
        mag      = r_value[31] ? (~r_value + 32'd1) : r_value;
        neg      = (r_func == FUNC_SIGNED) && r_value[31];
        dec_src  = (r_func == FUNC_SIGNED) ? mag : r_value;
        over_pos = !neg && (dec_src > UNSIGNED_MAX);
        over_neg = neg && (mag > NEG_MAG_MAX);
    end

    ssnf_decimal u_decimal (
        .i_bin (dec_src[13:0]),
        .o_dec (dec)
    );

    // leftmost digit shown in signed mode
    always_comb begin
        first = 2'(DIGIT_COUNT - 1);
        for (int i = DIGIT_COUNT - 2; i >= 0; i--) begin
            if (dec[i] != 4'd0) begin
                first = 2'(i);
            end
        end
    end

    // per-format segment patterns
    always_comb begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            n_digits[i] = 8'h00;
        end
        unique case (r_func)
            FUNC_HEX: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    n_digits[i] = hex_glyph(r_value[4*(DIGIT_COUNT-1-i) +: 4]);
                end
            end
            FUNC_UNSIGNED, FUNC_SIGNED: begin
                if (over_pos || over_neg) begin
                    n_digits[0] = over_neg ? SEG_MINUS : SEG_PLUS;
                    n_digits[1] = SEG_E;
                    n_digits[2] = SEG_R;
                    n_digits[3] = SEG_R;
                end else if (r_func == FUNC_UNSIGNED) begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        n_digits[i] = hex_glyph(dec[i]);
                    end
                end else begin
                    for (int i = 0; i < DIGIT_COUNT; i++) begin
                        if (2'(i) >= first) begin
                            n_digits[i] = hex_glyph(dec[i]);
                        end else if (neg && (2'(i) == first - 2'd1)) begin
                            n_digits[i] = SEG_MINUS;
                        end
                    end
                end
            end
            FUNC_ASCII: begin
                for (int i = 0; i < DIGIT_COUNT; i++) begin
                    n_digits[i] = glyph(r_value[8*i +: 8]);
                end
            end
            default: begin
                // blank and unused codes leave everything dark
            end
        endcase
        n_out.digit_zero  = n_digits[0];
        n_out.digit_one   = n_digits[1];
        n_out.digit_two   = n_digits[2];
        n_out.digit_three = n_digits[3];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // empty result register never pushes back
    a_no_stall_when_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall
    ) else $error("input stalled with an empty result register");

    // blank and unused codes give a dark display
    a_blank_dark: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        out_load && (r_func == FUNC_BLANK || r_func > FUNC_ASCII) |=> o_data == '0
    ) else $error("blank format lit segments");

    // unsigned overflow shows +ERR
    a_unsigned_err: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_func == FUNC_UNSIGNED && r_value > UNSIGNED_MAX
        |=> o_data.digit_zero == SEG_PLUS && o_data.digit_one == SEG_E
    ) else $error("unsigned overflow not flagged");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// tb: self-checking bench for the seven-segment number formatter
`timescale 1ns / 1ps

module tb;
    import ssnf_pkg::*;

    // selector codes with no format behind them, all show blank
    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;

    localparam int RANDOM_BEATS = 1300;
    localparam int DRAIN_CYCLES = 8;

    // receiver stall styles
    typedef enum int unsigned {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC,
        STALL_HOLD
    } t_stall_mode;

    // one directed row, want is only used when typed is set
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] value;
        logic        typed;
        t_out_beat   want;
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_beat  i_data = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_beat o_data;

    // typed expectation riding along with the beat on the input
    logic      beat_typed = 1'b0;
    t_out_beat beat_want = '0;

    t_out_beat   pending_digits [$];
    t_out_beat   digits_due;
    int unsigned fault_count = 0;
    int unsigned burst_left = 1;

    // digit order in the packed result is zero, one, two, three from msb down
    t_dir_row directed_rows [0:25] = '{
        '{FUNC_BLANK,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{FUNC_BLANK,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_RSVD5,    32'h1234_5678, 1'b1, 32'h0000_0000},
        '{FUNC_RSVD6,    32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{FUNC_RSVD7,    32'h8000_0001, 1'b1, 32'h0000_0000},
        '{FUNC_HEX,      32'h0000_0000, 1'b1, 32'h3F3F_3F3F},
        '{FUNC_HEX,      32'hFFFF_FFFF, 1'b1, 32'h7171_7171},
        '{FUNC_HEX,      32'h0123_4567, 1'b0, 32'h0000_0000},
        '{FUNC_HEX,      32'h89AB_CDEF, 1'b0, 32'h0000_0000},
        '{FUNC_UNSIGNED, 32'd0,         1'b1, 32'h3F3F_3F3F},
        '{FUNC_UNSIGNED, 32'd9999,      1'b1, 32'h6F6F_6F6F},
        '{FUNC_UNSIGNED, 32'd10000,     1'b1, 32'h7079_3333},
        '{FUNC_UNSIGNED, 32'hFFFF_FFFF, 1'b1, 32'h7079_3333},
        '{FUNC_UNSIGNED, 32'd407,       1'b0, 32'h0000_0000},
        '{FUNC_SIGNED,   32'd0,         1'b1, 32'h0000_003F},
        '{FUNC_SIGNED,   32'd9999,      1'b1, 32'h6F6F_6F6F},
        '{FUNC_SIGNED,   32'd10000,     1'b1, 32'h7079_3333},
        '{FUNC_SIGNED,   32'h7FFF_FFFF, 1'b1, 32'h7079_3333},
        '{FUNC_SIGNED,   32'hFFFF_FC19, 1'b1, 32'h406F_6F6F},
        '{FUNC_SIGNED,   32'hFFFF_FC18, 1'b1, 32'h4079_3333},
        '{FUNC_SIGNED,   32'h8000_0000, 1'b1, 32'h4079_3333},
        '{FUNC_SIGNED,   32'hFFFF_FFFB, 1'b1, 32'h0000_406D},
        '{FUNC_SIGNED,   32'hFFFF_FFD6, 1'b0, 32'h0000_0000},
        '{FUNC_SIGNED,   32'd1000,      1'b0, 32'h0000_0000},
        '{FUNC_ASCII,    32'h7F1F_2041, 1'b1, 32'h7700_0001},
        '{FUNC_ASCII,    32'hFF80_2E7E, 1'b1, 32'h0180_0000}
    };

    seven_segment_number_formatter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // font pattern for a character code, codes outside space..DEL show a space, DEL shows the tilde
    function automatic logic [7:0] char_segments(input logic [7:0] code);
        int unsigned slot;
        if (code < CHAR_SPACE || code > CHAR_DEL) begin
            return FONT[0];
        end
        slot = (code == CHAR_DEL) ? (CHAR_TILDE - CHAR_SPACE) : (code - CHAR_SPACE);
        return FONT[slot];
    endfunction

    // pattern for a numeral 0..15 as 0-9, A-F
    function automatic logic [7:0] numeral_segments(input int unsigned n);
        if (n < 10) begin
            return char_segments(8'(CHAR_ZERO + n));
        end
        return char_segments(8'(CHAR_A + n - 10));
    endfunction

    // four digit patterns shown for one input beat
    function automatic t_out_beat format_digits(input t_in_beat b);
        logic [7:0]  seg [DIGIT_COUNT];
        int unsigned dec [DIGIT_COUNT];
        int unsigned mag;
        int unsigned rest;
        int          lead;
        int          k;
        logic        neg;
        t_out_beat   r;
        for (k = 0; k < DIGIT_COUNT; k++) begin
            seg[k] = 8'h00;
        end
        neg = b.value[31];
        case (b.func)
            FUNC_HEX: begin
                for (k = 0; k < DIGIT_COUNT; k++) begin
                    seg[k] = numeral_segments(b.value[(12 - 4 * k) +: 4]);
                end
            end
            FUNC_UNSIGNED: begin
                if (b.value > UNSIGNED_MAX) begin
                    seg = '{SEG_PLUS, SEG_E, SEG_R, SEG_R};
                end else begin
                    rest = b.value;
                    for (k = DIGIT_COUNT - 1; k >= 0; k--) begin
                        seg[k] = numeral_segments(rest % 10);
                        rest = rest / 10;
                    end
                end
            end
            FUNC_SIGNED: begin
                mag = neg ? (~b.value + 32'd1) : b.value;
                if (neg && mag > NEG_MAG_MAX) begin
                    seg = '{SEG_MINUS, SEG_E, SEG_R, SEG_R};
                end else if (!neg && mag > UNSIGNED_MAX) begin
                    seg = '{SEG_PLUS, SEG_E, SEG_R, SEG_R};
                end else begin
                    rest = mag;
                    for (k = DIGIT_COUNT - 1; k >= 0; k--) begin
                        dec[k] = rest % 10;
                        rest = rest / 10;
                    end
                    // first nonzero digit, ones digit always shown
                    lead = DIGIT_COUNT - 1;
                    for (k = DIGIT_COUNT - 2; k >= 0; k--) begin
                        if (dec[k] != 0) begin
                            lead = k;
                        end
                    end
                    for (k = lead; k < DIGIT_COUNT; k++) begin
                        seg[k] = numeral_segments(dec[k]);
                    end
                    if (neg && lead > 0) begin
                        seg[lead - 1] = SEG_MINUS;
                    end
                end
            end
            FUNC_ASCII: begin
                for (k = 0; k < DIGIT_COUNT; k++) begin
                    seg[k] = char_segments(b.value[8 * k +: 8]);
                end
            end
            default: begin
            end
        endcase
        r.digit_zero  = seg[0];
        r.digit_one   = seg[1];
        r.digit_two   = seg[2];
        r.digit_three = seg[3];
        return r;
    endfunction

    // random beat, weighted toward values that land inside the decimal ranges
    function automatic t_in_beat random_beat();
        t_in_beat    b;
        int unsigned pick;
        int unsigned shape;
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        b.value = $urandom;
        if (pick < 8) begin
            b.func = FUNC_BLANK;
        end else if (pick < 14) begin
            b.func = 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
        end else if (pick < 32) begin
            b.func = FUNC_HEX;
        end else if (pick < 54) begin
            b.func = FUNC_UNSIGNED;
            if (shape < 20) begin
                b.value = $urandom_range(0, 99);
            end else if (shape < 50) begin
                b.value = $urandom_range(0, 9999);
            end else if (shape < 70) begin
                b.value = $urandom_range(9990, 10010);
            end
        end else if (pick < 84) begin
            b.func = FUNC_SIGNED;
            if (shape < 15) begin
                b.value = $urandom_range(0, 99);
            end else if (shape < 35) begin
                b.value = $urandom_range(0, 9999);
            end else if (shape < 50) begin
                b.value = 32'd0 - $urandom_range(1, 999);
            end else if (shape < 60) begin
                b.value = 32'd0 - $urandom_range(1, 99);
            end else if (shape < 68) begin
                b.value = $urandom_range(9990, 10010);
            end else if (shape < 76) begin
                b.value = 32'd0 - $urandom_range(990, 1010);
            end else if (shape < 84) begin
                b.value = 32'h8000_0000 ^ $urandom_range(0, 15);
            end
        end else begin
            b.func = FUNC_ASCII;
            if (shape < 60) begin
                b.value = {8'($urandom_range(32, 127)), 8'($urandom_range(32, 127)),
                           8'($urandom_range(32, 127)), 8'($urandom_range(32, 127))};
            end
        end
        return b;
    endfunction

    // present one beat, hold it until taken, then idle between bursts
    task automatic send_beat(input t_in_beat beat, input logic typed, input t_out_beat want);
        int unsigned gap;
        i_valid    <= 1'b1;
        i_data     <= beat;
        beat_typed <= typed;
        beat_want  <= want;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) begin
                    i_data <= 35'({$urandom, $urandom});
                    @(negedge i_clk);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fault_count++;
        end
    endtask

    // record accepted inputs, check accepted results in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall === 1'b0) begin
                pending_digits.push_back(beat_typed ? beat_want : format_digits(i_data));
            end
            if (i_stall === 1'b0 && o_valid !== 1'b0) begin
                if (pending_digits.size() == 0) begin
                    $error("result beat %h with no input beat outstanding", o_data);
                    fault_count++;
                end else begin
                    digits_due = pending_digits.pop_front();
                    check_field("digit_zero", digits_due.digit_zero, o_data.digit_zero);
                    check_field("digit_one", digits_due.digit_one, o_data.digit_one);
                    check_field("digit_two", digits_due.digit_two, o_data.digit_two);
                    check_field("digit_three", digits_due.digit_three, o_data.digit_three);
                end
            end
        end
    end

    // receiver stall, changing style every stretch
    initial begin : receiver_pattern
        t_stall_mode mode;
        int unsigned span;
        int unsigned period;
        int unsigned k;
        forever begin
            mode   = t_stall_mode'($urandom_range(STALL_NONE, STALL_HOLD));
            span   = $urandom_range(20, 150);
            period = $urandom_range(2, 5);
            for (k = 0; k < span; k++) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:     i_stall <= 1'b0;
                    STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: i_stall <= (k % period == 0);
                    default:        i_stall <= (k < 12);
                endcase
            end
        end
    end

    // reset, directed rows, random beats, drain
    initial begin : stimulus
        int n;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (n = 0; n < $size(directed_rows); n++) begin
            send_beat({directed_rows[n].func, directed_rows[n].value},
                      directed_rows[n].typed, directed_rows[n].want);
        end
        repeat (RANDOM_BEATS) begin
            send_beat(random_beat(), 1'b0, '0);
        end
        i_valid <= 1'b0;
        while (pending_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("PASS seven_segment_number_formatter");
        end else begin
            $display("FAIL seven_segment_number_formatter");
        end
        $finish;
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("FAIL seven_segment_number_formatter");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ssnf_pkg.sv
rtl/ssnf_decimal.sv
rtl/seven_segment_number_formatter.sv
bench/tb.sv
